>>> src/fvnh_pkg.sv
// Shared types, widths and constants for the fractal value-noise heightmap block.
package fvnh_pkg;

  localparam int CMD_W      = 1;
  localparam int ROW_W      = 7;
  localparam int SAMPLE_W   = 8;
  localparam int HEIGHT_W   = 8;
  localparam int GRID_CFG_W = 8;
  localparam int FREQ_W     = 5;
  localparam int OCT_CFG_W  = 4;
  localparam int PERS_W     = 16;
  localparam int RAD_CFG_W  = 3;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam int DIV_W  = 32;
  localparam int MUL_W  = 17;
  localparam int PROD_W = 2 * MUL_W;
  localparam int FRAC_W = 16;

  localparam logic [MUL_W-1:0]  ONE_Q16  = 17'h10000;
  localparam logic [PERS_W-1:0] FREQ_SAT = 16'hFFFF;
  localparam int                MIN_GRID = 2;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

  localparam logic [GRID_CFG_W-1:0] GRID_SIZE_RST = 8'd128;
  localparam logic [FREQ_W-1:0]     BASE_FREQ_RST = 5'd4;
  localparam logic [OCT_CFG_W-1:0]  OCTAVES_RST   = 4'd4;
  localparam logic [PERS_W-1:0]     PERSIST_RST   = 16'd32768;
  localparam logic [RAD_CFG_W-1:0]  RADIUS_RST    = 3'd1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_GRID_SIZE = 3'd0,
    CFG_BASE_FREQ = 3'd1,
    CFG_OCTAVES   = 3'd2,
    CFG_PERSIST   = 3'd3,
    CFG_RADIUS    = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_WIN_CHECK,
    ST_OCT_F,
    ST_BND_Q,
    ST_BND_Q_W,
    ST_BND_LO,
    ST_BND_LO_W,
    ST_BND_HI,
    ST_BND_HI_W,
    ST_RD,
    ST_BL_A,
    ST_BL_A_W,
    ST_BL_SQ,
    ST_BL_CU,
    ST_BL_W,
    ST_MIX_A,
    ST_MIX_B,
    ST_ACC,
    ST_WUPD,
    ST_CELL_DIV,
    ST_CELL_W,
    ST_WIN_NEXT,
    ST_FIN_DIV,
    ST_FIN_W,
    ST_OUT
  } state_t;

endpackage

>>> src/fvnh_if.sv
// Valid/ready channel interfaces for the query input and the height output.
interface fvnh_in_if;
  import fvnh_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [ROW_W-1:0]    row;
  logic [ROW_W-1:0]    col;
  logic [SAMPLE_W-1:0] sample;
  modport source (output valid, cmd, row, col, sample, input ready);
  modport sink (input valid, cmd, row, col, sample, output ready);
endinterface

interface fvnh_out_if;
  import fvnh_pkg::*;
  logic                valid;
  logic                ready;
  logic [HEIGHT_W-1:0] height;
  logic                out_of_range;
  modport source (output valid, height, out_of_range, input ready);
  modport sink (input valid, height, out_of_range, output ready);
endinterface

>>> src/fvnh_div.sv
// Restoring divider, one quotient bit per cycle, shared by the whole datapath.
module fvnh_div (
  input  logic               clk,
  input  logic               rst,
  input  fvnh_pkg::div_req_t req,
  output fvnh_pkg::div_rsp_t rsp
);
  import fvnh_pkg::*;

  localparam int STEP_W = $clog2(DIV_W);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [DIV_W-1:0]  quo;
  logic [DIV_W-1:0]  dvs;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W:0]    shifted;
  logic [DIV_W:0]    diff;
  logic              ge;

  always_comb begin
    shifted = {rem, quo[DIV_W-1]};
    ge      = shifted >= {1'b0, dvs};
    diff    = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      quo <= {quo[DIV_W-2:0], ge};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

`ifndef NO_ASSERTIONS
  a_no_restart: assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("divider restarted while busy");
  a_nonzero_divisor: assert property (@(posedge clk) disable iff (rst)
    req.start |-> req.divisor != '0)
    else $error("division by zero requested");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("quotient flagged without a division in flight");
`endif

endmodule

>>> src/fvnh_grid_ram.sv
// Sample grid memory: one write port, one read port with registered data.
module fvnh_grid_ram #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [fvnh_pkg::SAMPLE_W-1:0] wdata,
  input  logic [AW-1:0]                 raddr,
  output logic [fvnh_pkg::SAMPLE_W-1:0] rdata
);
  import fvnh_pkg::*;

  logic [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> src/fractal_value_noise_heightmap_core.sv
// Fractal value-noise heightmap: the sample grid, the query sequencer and the datapath.
//
// Input channel in_ch carries one transaction per item. cmd = load writes the
// sample byte to (row, col) and finishes in the cycle it is accepted, so loads
// stream at one per cycle while no query is in flight. cmd = query computes the
// height of (row, col) and returns one transaction on out_ch; an out-of-range
// query skips the window walk and goes straight to the output state.
// A query walks the in-grid cells of its box window; for each cell and octave
// it runs six bound divisions, up to two blend divisions, four grid reads and
// about twenty multiply steps, then one normalizing division per cell and one
// averaging division at the end. Every division runs on the shared serial
// divider, which sets the latency.
// in_ch.ready is high only while no query is in flight. The result sits in an
// output register, so a stalled receiver does not stop the next item from
// being accepted; a second result waits inside the block until the first is
// taken. The user must write configuration on cfg_write only while idle; the
// block itself does not enforce this. Reset sets the control and configuration
// registers to their defaults; the grid contents stay undefined until loaded.
module fractal_value_noise_heightmap_core #(
  parameter int GRID_MAX    = 128,
  parameter int MAX_OCTAVES = 8,
  parameter int MAX_RADIUS  = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  fvnh_in_if.sink                          in_ch,
  fvnh_out_if.source                       out_ch,
  input  logic                             cfg_write,
  input  logic [fvnh_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fvnh_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fvnh_pkg::*;

  localparam int CW      = $clog2(GRID_MAX);
  localparam int GW      = $clog2(GRID_MAX + 1);
  localparam int DEPTH   = GRID_MAX * GRID_MAX;
  localparam int AW      = $clog2(DEPTH);
  localparam int KW      = $clog2((1 << ROW_W) + MAX_RADIUS) + 1;
  localparam int OW      = $clog2(MAX_OCTAVES + 1);
  localparam int RW      = $clog2(MAX_RADIUS + 2);
  localparam int CNT_MAX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int NW      = $clog2(CNT_MAX + 1);
  localparam int SW      = HEIGHT_W + NW;
  localparam int ACC_W   = HEIGHT_W + PERS_W + OW;
  localparam int WS_W    = PERS_W + OW;
  localparam int MIX_W   = HEIGHT_W + MUL_W;

  // configuration
  logic [GRID_CFG_W-1:0] cfg_grid;
  logic [FREQ_W-1:0]     cfg_freq;
  logic [OCT_CFG_W-1:0]  cfg_oct;
  logic [PERS_W-1:0]     cfg_pers;
  logic [RAD_CFG_W-1:0]  cfg_rad;

  logic [GW-1:0]     g_eff;
  logic [FREQ_W-1:0] fb_eff;
  logic [OW-1:0]     oc_eff;
  logic [PERS_W-1:0] p_eff;
  logic [RW-1:0]     r_eff;

  state_t state, state_next;

  logic [ROW_W-1:0]        qrow, qcol;
  logic signed [KW-1:0]    k, l;
  logic [SW-1:0]           sum;
  logic [NW-1:0]           cnt;
  logic [OW-1:0]           n;
  logic [PERS_W-1:0]       f, w, q;
  logic [ACC_W-1:0]        acc;
  logic [WS_W-1:0]         wsum;
  logic                    axis, bph;
  logic [1:0]              mix_sel;
  logic [2:0]              cidx;
  logic [CW-1:0]           x1, x2, y1, y2;
  logic [SAMPLE_W-1:0]     corner [4];
  logic [MUL_W-1:0]        a, sq, cu, w2;
  logic [MIX_W-1:0]        hold;
  logic [HEIGHT_W-1:0]     v1, v2, v;
  logic [HEIGHT_W-1:0]     res_height;
  logic                    res_oor;
  logic                    out_valid;
  logic [HEIGHT_W-1:0]     out_height;
  logic                    out_oor;

  logic                    accept, oor, in_win, out_free, last_col, last_row;
  logic [CW-1:0]           x, y, cur, span, d;
  logic signed [KW-1:0]    lmin, lmax, kmax;
  logic [MUL_W-1:0]        mul_a, mul_b, w1;
  logic [PROD_W-1:0]       prod;
  logic [HEIGHT_W-1:0]     ya, yb, mix_val;
  logic [MUL_W+1:0]        w2_raw;
  logic [MIX_W:0]          mixed;
  logic [CW-1:0]           rd_row, rd_col;
  logic [DIV_W-1:0]        hi_clamp;

  logic                    mem_we;
  logic [AW-1:0]           mem_waddr, mem_raddr;
  logic [SAMPLE_W-1:0]     mem_rdata;
  div_req_t                div_req;
  div_rsp_t                div_rsp;

  // effective configuration
  always_comb begin
    if (cfg_grid < GRID_CFG_W'(MIN_GRID)) g_eff = GW'(MIN_GRID);
    else if (GW'(cfg_grid) > GW'(GRID_MAX)) g_eff = GW'(GRID_MAX);
    else g_eff = GW'(cfg_grid);
    fb_eff = (cfg_freq == '0) ? FREQ_W'(1) : cfg_freq;
    if (cfg_oct == '0) oc_eff = OW'(1);
    else if (32'(cfg_oct) > MAX_OCTAVES) oc_eff = OW'(MAX_OCTAVES);
    else oc_eff = OW'(cfg_oct);
    p_eff = (cfg_pers == '0) ? PERS_W'(1) : cfg_pers;
    r_eff = (32'(cfg_rad) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(cfg_rad);
  end

  // cell, window and blend selects
  always_comb begin
    accept   = in_ch.valid && (state == ST_IDLE);
    oor      = (GW'(in_ch.row) >= g_eff) || (GW'(in_ch.col) >= g_eff);
    in_win   = !k[KW-1] && !l[KW-1]
               && ({{GW{1'b0}}, k} < {{KW{1'b0}}, g_eff})
               && ({{GW{1'b0}}, l} < {{KW{1'b0}}, g_eff});
    x        = k[CW-1:0];
    y        = l[CW-1:0];
    cur      = axis ? y : x;
    span     = bph ? (x2 - x1) : (y2 - y1);
    d        = bph ? (x - x1) : (y - y1);
    lmin     = KW'(qcol) - KW'(r_eff);
    lmax     = KW'(qcol) + KW'(r_eff);
    kmax     = KW'(qrow) + KW'(r_eff);
    last_col = (l == lmax);
    last_row = (k == kmax);
    out_free = !out_valid || out_ch.ready;
    w1       = ONE_Q16 - w2;
    unique case (mix_sel)
      2'd0:    begin ya = corner[0]; yb = corner[1]; end
      2'd1:    begin ya = corner[2]; yb = corner[3]; end
      default: begin ya = v1;        yb = v2;        end
    endcase
    rd_row   = cidx[1] ? x2 : x1;
    rd_col   = cidx[0] ? y2 : y1;
    hi_clamp = 32'(g_eff) - 32'd1;
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_OCT_F:  begin mul_a = MUL_W'(f);   mul_b = MUL_W'(fb_eff); end
      ST_BND_Q:  begin mul_a = MUL_W'(cur); mul_b = MUL_W'(f);      end
      ST_BND_LO: begin mul_a = MUL_W'(q);   mul_b = MUL_W'(g_eff);  end
      ST_BND_HI: begin mul_a = MUL_W'(q) + MUL_W'(1); mul_b = MUL_W'(g_eff); end
      ST_BL_SQ:  begin mul_a = a;           mul_b = a;              end
      ST_BL_CU:  begin mul_a = sq;          mul_b = a;              end
      ST_MIX_A:  begin mul_a = MUL_W'(ya);  mul_b = w1;             end
      ST_MIX_B:  begin mul_a = MUL_W'(yb);  mul_b = w2;             end
      ST_ACC:    begin mul_a = MUL_W'(v);   mul_b = MUL_W'(w);      end
      ST_WUPD:   begin mul_a = MUL_W'(w);   mul_b = MUL_W'(p_eff);  end
      default:   begin mul_a = '0;          mul_b = '0;             end
    endcase
    prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
    w2_raw  = (MUL_W+2)'(sq) + (MUL_W+2)'({sq, 1'b0}) - (MUL_W+2)'({cu, 1'b0});
    mixed   = (MIX_W+1)'(hold) + (MIX_W+1)'(prod[MIX_W-1:0]);
    mix_val = mixed[FRAC_W+HEIGHT_W-1:FRAC_W];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (accept && in_ch.cmd == CMD_QUERY) state_next = oor ? ST_OUT : ST_WIN_CHECK;
      ST_WIN_CHECK: state_next = in_win ? ST_OCT_F : ST_WIN_NEXT;
      ST_OCT_F:     state_next = ST_BND_Q;
      ST_BND_Q:     state_next = ST_BND_Q_W;
      ST_BND_Q_W:   if (div_rsp.done) state_next = ST_BND_LO;
      ST_BND_LO:    state_next = ST_BND_LO_W;
      ST_BND_LO_W:  if (div_rsp.done) state_next = ST_BND_HI;
      ST_BND_HI:    state_next = ST_BND_HI_W;
      ST_BND_HI_W:  if (div_rsp.done) state_next = axis ? ST_RD : ST_BND_Q;
      ST_RD:        if (cidx == 3'd4) state_next = ST_BL_A;
      ST_BL_A:      state_next = (span == '0) ? ST_MIX_A : ST_BL_A_W;
      ST_BL_A_W:    if (div_rsp.done) state_next = ST_BL_SQ;
      ST_BL_SQ:     state_next = ST_BL_CU;
      ST_BL_CU:     state_next = ST_BL_W;
      ST_BL_W:      state_next = ST_MIX_A;
      ST_MIX_A:     state_next = ST_MIX_B;
      ST_MIX_B: begin
        if (mix_sel == 2'd0) state_next = ST_MIX_A;
        else if (mix_sel == 2'd1) state_next = ST_BL_A;
        else state_next = ST_ACC;
      end
      ST_ACC:       state_next = ST_WUPD;
      ST_WUPD:      state_next = (OW'(n + 1'b1) == oc_eff) ? ST_CELL_DIV : ST_OCT_F;
      ST_CELL_DIV:  state_next = ST_CELL_W;
      ST_CELL_W:    if (div_rsp.done) state_next = ST_WIN_NEXT;
      ST_WIN_NEXT:  state_next = (last_col && last_row) ? ST_FIN_DIV : ST_WIN_CHECK;
      ST_FIN_DIV:   state_next = ST_FIN_W;
      ST_FIN_W:     if (div_rsp.done) state_next = ST_OUT;
      ST_OUT:       if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer: handshake, memory ports, divider requests
  always_comb begin
    in_ch.ready      = (state == ST_IDLE);
    mem_we           = accept && (in_ch.cmd == CMD_LOAD)
                       && (32'(in_ch.row) < GRID_MAX) && (32'(in_ch.col) < GRID_MAX);
    mem_waddr        = AW'(32'(in_ch.row) * GRID_MAX + 32'(in_ch.col));
    mem_raddr        = AW'(32'(rd_row) * GRID_MAX + 32'(rd_col));
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    unique case (state)
      ST_BND_Q: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod[DIV_W-1:0];
        div_req.divisor  = DIV_W'(g_eff);
      end
      ST_BND_LO, ST_BND_HI: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod[DIV_W-1:0];
        div_req.divisor  = DIV_W'(f);
      end
      ST_BL_A: begin
        div_req.start    = (span != '0);
        div_req.dividend = DIV_W'({d, {FRAC_W{1'b0}}});
        div_req.divisor  = DIV_W'(span);
      end
      ST_CELL_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(acc);
        div_req.divisor  = DIV_W'(wsum);
      end
      ST_FIN_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(sum);
        div_req.divisor  = DIV_W'(cnt);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      cfg_grid  <= GRID_SIZE_RST;
      cfg_freq  <= BASE_FREQ_RST;
      cfg_oct   <= OCTAVES_RST;
      cfg_pers  <= PERSIST_RST;
      cfg_rad   <= RADIUS_RST;
    end else begin
      state <= state_next;
      if (state == ST_OUT && out_free) out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_GRID_SIZE: cfg_grid <= cfg_data[GRID_CFG_W-1:0];
          CFG_BASE_FREQ: cfg_freq <= cfg_data[FREQ_W-1:0];
          CFG_OCTAVES:   cfg_oct  <= cfg_data[OCT_CFG_W-1:0];
          CFG_PERSIST:   cfg_pers <= cfg_data[PERS_W-1:0];
          CFG_RADIUS:    cfg_rad  <= cfg_data[RAD_CFG_W-1:0];
          default:       ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      out_height <= res_height;
      out_oor    <= res_oor;
    end
    case (state)
      ST_IDLE: begin
        if (accept) begin
          qrow       <= in_ch.row;
          qcol       <= in_ch.col;
          k          <= KW'(in_ch.row) - KW'(r_eff);
          l          <= KW'(in_ch.col) - KW'(r_eff);
          sum        <= '0;
          cnt        <= '0;
          res_height <= '0;
          res_oor    <= oor;
        end
      end
      ST_WIN_CHECK: begin
        f    <= PERS_W'(1);
        w    <= p_eff;
        acc  <= '0;
        wsum <= '0;
        n    <= '0;
      end
      ST_OCT_F: begin
        f       <= (prod > PROD_W'(FREQ_SAT)) ? FREQ_SAT : prod[PERS_W-1:0];
        axis    <= 1'b0;
        bph     <= 1'b0;
        mix_sel <= 2'd0;
        cidx    <= 3'd0;
      end
      ST_BND_Q_W: if (div_rsp.done) q <= div_rsp.quotient[PERS_W-1:0];
      ST_BND_LO_W: begin
        if (div_rsp.done) begin
          if (axis) y1 <= div_rsp.quotient[CW-1:0];
          else x1 <= div_rsp.quotient[CW-1:0];
        end
      end
      ST_BND_HI_W: begin
        if (div_rsp.done) begin
          // clamp the upper lattice line to the last row or column
          if (axis) begin
            y2 <= (div_rsp.quotient > hi_clamp) ? hi_clamp[CW-1:0] : div_rsp.quotient[CW-1:0];
          end else begin
            x2 <= (div_rsp.quotient > hi_clamp) ? hi_clamp[CW-1:0] : div_rsp.quotient[CW-1:0];
          end
          axis <= 1'b1;
        end
      end
      ST_RD: begin
        cidx <= cidx + 3'd1;
        if (cidx != 3'd0) corner[2'(cidx - 3'd1)] <= mem_rdata;
      end
      ST_BL_A:   if (span == '0) w2 <= '0;
      ST_BL_A_W: if (div_rsp.done) a <= div_rsp.quotient[MUL_W-1:0];
      ST_BL_SQ:  sq <= prod[FRAC_W+MUL_W-1:FRAC_W];
      ST_BL_CU:  cu <= prod[FRAC_W+MUL_W-1:FRAC_W];
      ST_BL_W:   w2 <= (w2_raw > (MUL_W+2)'(ONE_Q16)) ? ONE_Q16 : w2_raw[MUL_W-1:0];
      ST_MIX_A:  hold <= prod[MIX_W-1:0];
      ST_MIX_B: begin
        case (mix_sel)
          2'd0: begin
            v1      <= mix_val;
            mix_sel <= 2'd1;
          end
          2'd1: begin
            v2      <= mix_val;
            mix_sel <= 2'd2;
            bph     <= 1'b1;
          end
          default: v <= mix_val;
        endcase
      end
      ST_ACC: begin
        acc  <= acc + ACC_W'(prod[HEIGHT_W+PERS_W-1:0]);
        wsum <= wsum + WS_W'(w);
      end
      ST_WUPD: begin
        w <= prod[FRAC_W+PERS_W-1:FRAC_W];
        n <= n + 1'b1;
      end
      ST_CELL_W: begin
        if (div_rsp.done) begin
          sum <= sum + SW'(div_rsp.quotient[HEIGHT_W-1:0]);
          cnt <= cnt + 1'b1;
        end
      end
      ST_WIN_NEXT: begin
        // advance along the row, wrap to the next window row
        if (last_col) begin
          l <= lmin;
          k <= k + 1'b1;
        end else begin
          l <= l + 1'b1;
        end
      end
      ST_FIN_W: begin
        if (div_rsp.done) begin
          res_height <= div_rsp.quotient[HEIGHT_W-1:0];
          res_oor    <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.height       = out_height;
  assign out_ch.out_of_range = out_oor;

  fvnh_grid_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_grid_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_ch.sample),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fvnh_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

`ifndef NO_ASSERTIONS
  a_write_when_idle: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state == ST_IDLE)
    else $error("grid written while a query is in flight");
  a_cell_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN_DIV |-> cnt != '0)
    else $error("window average with no cells");
  a_offset_in_span: assert property (@(posedge clk) disable iff (rst)
    state == ST_BL_A |-> d <= span)
    else $error("blend offset beyond lattice span");
  a_octave_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_WUPD |-> n < oc_eff)
    else $error("octave counter overran");
`endif

endmodule
